// File: rtl/crc_checked_record_decoder_core_assert.svh
`ifndef CRC_CHECKED_RECORD_DECODER_CORE_ASSERT_SVH
`define CRC_CHECKED_RECORD_DECODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCCRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CCCRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cccrd_pkg.sv
package cccrd_pkg;

	localparam logic [15:0] CRC_POLY = 16'h8005;

	localparam int ADDR_W = 5;

	localparam logic [ADDR_W-1:0] ADDR_MAGIC0   = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_MAGIC1   = 5'd1;
	localparam logic [ADDR_W-1:0] ADDR_CAGE0    = 5'd2;
	localparam logic [ADDR_W-1:0] ADDR_NAME_LO0 = 5'd4;
	localparam logic [ADDR_W-1:0] ADDR_NAME_HI0 = 5'd12;
	localparam logic [ADDR_W-1:0] ADDR_STAMP0   = 5'd16;
	localparam logic [ADDR_W-1:0] ADDR_CRC_LO   = 5'd20;
	localparam logic [ADDR_W-1:0] ADDR_LAST     = 5'd21;
	localparam logic [ADDR_W-1:0] ADDR_DONE     = 5'd22;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNPROG  = 2'd1,
		ST_CRC_ERR = 2'd2
	} status_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rec_byte;
		logic       rec_start;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] cage_number;
		logic [63:0] name_low;
		logic [23:0] name_high;
		logic [31:0] stamp;
	} result_t;

	// byte-wide crc-16 update, msb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/crc_checked_record_decoder_core.sv
// Record decoder: takes a stored 22-byte record one byte per item, from address 0 (rec_start
// restarts it), checks the two magic bytes against magic_first and magic_second, runs a
// CRC-16 (poly 0x8005, init 0, msb first) over bytes 0 to 19 and compares it with the
// little-endian CRC in bytes 20 and 21, then gives one result item: ok with the cage number,
// name and timestamp, or unprogrammed / crc error with all fields zero. Bytes after 21 give
// nothing until the next rec_start. One byte is taken every cycle; the parse stage does the
// byte-wide CRC update and field capture; byte 21 goes via the input register to the output
// register behind out_valid. Input stalls only while a finished result is held and stalled
// on the output and the next byte 21 is in the parse stage. Configuration is written on cfg_we.
module crc_checked_record_decoder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cccrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rec_byte,
	input  logic                                 rec_start,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [15:0]                          cage_number,
	output logic [63:0]                          name_low,
	output logic [23:0]                          name_high,
	output logic [31:0]                          stamp
);
	import cccrd_pkg::*;

	logic [7:0] magic_first_q;
	logic [7:0] magic_second_q;
	in_item_t   item;
	result_t    res;
	result_t    res_q;
	logic       last;
	logic       out_free;
	logic       fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= '0;
			magic_second_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAGIC_FIRST:  magic_first_q  <= cfg_data;
				CFG_MAGIC_SECOND: magic_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid || !out_stall;
	assign fire     = item.valid && (!last || out_free);

	cccrd_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rec_byte  (rec_byte),
		.rec_start (rec_start),
		.fire      (fire),
		.item      (item)
	);

	cccrd_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.fire         (fire),
		.magic_first  (magic_first_q),
		.magic_second (magic_second_q),
		.last         (last),
		.res          (res)
	);

	cccrd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && last),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign status      = res_q.status;
	assign cage_number = res_q.cage_number;
	assign name_low    = res_q.name_low;
	assign name_high   = res_q.name_high;
	assign stamp       = res_q.stamp;

endmodule

// File: rtl/cccrd_in_reg.sv
module cccrd_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rec_byte,
	input  logic                rec_start,
	input  logic                fire,
	output cccrd_pkg::in_item_t item
);
	import cccrd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       load_en;

	assign load_en  = !valid_s1 || fire;
	assign in_stall = !load_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && in_valid) begin
			byte_s1  <= rec_byte;
			start_s1 <= rec_start;
		end
	end

	assign item.valid     = valid_s1;
	assign item.rec_byte  = byte_s1;
	assign item.rec_start = start_s1;

endmodule

// File: rtl/cccrd_parse.sv
module cccrd_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  cccrd_pkg::in_item_t item,
	input  logic                fire,
	input  logic [7:0]          magic_first,
	input  logic [7:0]          magic_second,
	output logic                last,
	output cccrd_pkg::result_t  res
);
	import cccrd_pkg::*;

	logic [ADDR_W-1:0] count_q;
	logic [15:0]       crc_q;
	logic              match_q;
	logic [7:0]        crc_lo_q;
	logic [15:0]       cage_q;
	logic [63:0]       name_lo_q;
	logic [23:0]       name_hi_q;
	logic [31:0]       stamp_q;

	logic [ADDR_W-1:0] addr;
	logic              active;
	logic              step;
	logic [15:0]       crc_base;
	logic [15:0]       stored;

	assign addr     = item.rec_start ? '0 : count_q;
	assign active   = addr < ADDR_DONE;
	assign step     = fire && active;
	assign last     = item.valid && (addr == ADDR_LAST);
	assign crc_base = (addr == ADDR_MAGIC0) ? '0 : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= '0;
			match_q <= 1'b0;
		end else if (step) begin
			count_q <= addr + 5'd1;
			if (addr < ADDR_CRC_LO) begin
				crc_q <= crc_feed(crc_base, item.rec_byte);
			end
			if (addr == ADDR_MAGIC0) begin
				match_q <= (item.rec_byte == magic_first);
			end else if (addr == ADDR_MAGIC1) begin
				match_q <= match_q && (item.rec_byte == magic_second);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < 2; i++) begin
				if (addr == ADDR_CAGE0 + 5'(i)) cage_q[i*8 +: 8] <= item.rec_byte;
			end
			for (int i = 0; i < 8; i++) begin
				if (addr == ADDR_NAME_LO0 + 5'(i)) name_lo_q[i*8 +: 8] <= item.rec_byte;
			end
			for (int i = 0; i < 3; i++) begin
				if (addr == ADDR_NAME_HI0 + 5'(i)) name_hi_q[i*8 +: 8] <= item.rec_byte;
			end
			for (int i = 0; i < 4; i++) begin
				if (addr == ADDR_STAMP0 + 5'(i)) stamp_q[i*8 +: 8] <= item.rec_byte;
			end
			if (addr == ADDR_CRC_LO) crc_lo_q <= item.rec_byte;
		end
	end

	assign stored = {item.rec_byte, crc_lo_q};

	always_comb begin
		res = '0;
		if (!match_q) begin
			res.status = ST_UNPROG;
		end else if (stored != crc_q) begin
			res.status = ST_CRC_ERR;
		end else begin
			res.status      = ST_OK;
			res.cage_number = cage_q;
			res.name_low    = name_lo_q;
			res.name_high   = name_hi_q;
			res.stamp       = stamp_q;
		end
	end

endmodule

// File: rtl/cccrd_out_reg.sv
module cccrd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  cccrd_pkg::result_t res,
	input  logic               out_stall,
	output logic               out_valid,
	output cccrd_pkg::result_t res_q
);
	import cccrd_pkg::*;

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule

// File: rtl/cccrd_checker.sv
`include "crc_checked_record_decoder_core_assert.svh"

module cccrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] cage_number,
	input logic [63:0] name_low,
	input logic [23:0] name_high,
	input logic [31:0] stamp
);
	import cccrd_pkg::*;

	`CCCRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped while stalled")
	`CCCRD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(stamp) && $stable(cage_number), "stalled result item changed")
	`CCCRD_ASSERT_NOW(a_status_code, out_valid, status == ST_OK || status == ST_UNPROG || status == ST_CRC_ERR, "status code out of range")
	`CCCRD_ASSERT_NOW(a_fields_zero, out_valid && status != ST_OK, cage_number == '0 && name_low == '0 && name_high == '0 && stamp == '0, "fields not zero on failed record")

endmodule

bind crc_checked_record_decoder_core cccrd_checker u_cccrd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.cage_number (cage_number),
	.name_low    (name_low),
	.name_high   (name_high),
	.stamp       (stamp)
);
